// File: hw/rtl/assert_macros.svh
// Assertion macros used by the car update top level.
// Depends on a clock named clk and a reset named rst in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/tcacu_pkg.sv
// Shared types and constants for the traffic car update block.
// No dependencies; imported by every module of the block but the car RAM.
package tcacu_pkg;

  localparam int CAR_SLOTS = 256;
  localparam int SLOT_BITS = $clog2(CAR_SLOTS);
  localparam int PROB_BITS = 16;
  localparam int DIV_BITS  = 17;
  localparam int CNT_BITS  = $clog2(DIV_BITS + 1);

  // configuration register indexes
  localparam logic [2:0] CFG_MODEL_OPTIONS  = 3'd0;
  localparam logic [2:0] CFG_TOP_SPEED      = 3'd1;
  localparam logic [2:0] CFG_FLOOR_SPEED    = 3'd2;
  localparam logic [2:0] CFG_SLOWDOWN_THR   = 3'd3;
  localparam logic [2:0] CFG_ACCEL_THR      = 3'd4;
  localparam logic [2:0] CFG_SLOW_START_THR = 3'd5;
  localparam logic [2:0] CFG_ROAD_LENGTH    = 3'd6;
  localparam logic [2:0] CFG_VEHICLE_LENGTH = 3'd7;

  // model_options bit positions
  localparam int OPT_SLOW_TO_STOP  = 0;
  localparam int OPT_TRUE_SLOWDOWN = 1;
  localparam int OPT_PERIODIC      = 2;

  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_ENTER  = 1'b1;

  typedef struct packed {
    logic [2:0]  model_options;
    logic [5:0]  top_speed;
    logic [5:0]  floor_speed;
    logic [15:0] slowdown_threshold;
    logic [15:0] accel_threshold;
    logic [15:0] slow_start_threshold;
    logic [15:0] road_length;
    logic [3:0]  vehicle_length;
  } cfg_t;

  typedef struct packed {
    logic              mode;
    logic [7:0]        car_slot;
    logic [15:0]       gap_cells;
    logic signed [7:0] ahead_speed;
    logic [15:0]       draw_one;
    logic [15:0]       draw_two;
  } cmd_t;

  typedef struct packed {
    logic [5:0]  speed_out;
    logic [15:0] position_out;
    logic        lap_done;
    logic        left_road;
    logic        start_pending;
  } res_t;

  // one table entry: speed, pending slow-start flag, position
  typedef struct packed {
    logic [5:0]  speed;
    logic        pending;
    logic [15:0] position;
  } car_rec_t;

  localparam int REC_BITS = $bits(car_rec_t);

endpackage

// File: hw/rtl/tcacu_car_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module tcacu_car_ram #(
  parameter int ADDR_BITS = 8,
  parameter int DATA_BITS = 23
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [DATA_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [DATA_BITS-1:0] rd_data
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/tcacu_speed_rule.sv
// Speed update for one car: basic rule or slow-to-stop rule.
// Depends on tcacu_pkg.
module tcacu_speed_rule (
  input  tcacu_pkg::cfg_t     cfg,
  input  tcacu_pkg::cmd_t     item,
  input  tcacu_pkg::car_rec_t cur,
  output logic [5:0]          new_speed,
  output logic                new_pending
);
  import tcacu_pkg::*;

  logic signed [17:0] v, g, vn, va, top_s, flr;
  logic hit_acc, hit_ss, hit_sd, acc, modified;

  always_comb begin
    hit_acc  = item.draw_one[PROB_BITS-1:0] <= cfg.accel_threshold[PROB_BITS-1:0];
    hit_ss   = item.draw_one[PROB_BITS-1:0] <= cfg.slow_start_threshold[PROB_BITS-1:0];
    hit_sd   = item.draw_two[PROB_BITS-1:0] <= cfg.slowdown_threshold[PROB_BITS-1:0];
    v        = $signed({12'd0, cur.speed});
    g        = $signed({2'd0, item.gap_cells});
    vn       = $signed({{10{item.ahead_speed[7]}}, item.ahead_speed});
    top_s    = $signed({12'd0, cfg.top_speed});
    flr      = $signed({12'd0, cfg.floor_speed});
    va       = v;
    acc      = 1'b0;
    modified = 1'b0;
    new_pending = cur.pending;

    if (!cfg.model_options[OPT_SLOW_TO_STOP]) begin
      if (hit_acc && v < top_s && g > v) begin
        va  = v + 18'sd1;
        acc = 1'b1;
      end
      if (va > g) begin
        va = g;
      end
      if (hit_sd && va > flr) begin
        va = va - 18'sd1;
        if (cfg.model_options[OPT_TRUE_SLOWDOWN] && acc && va > 18'sd0) begin
          va = va - 18'sd1;
        end
      end
    end else if (cur.pending) begin
      // held start: crawl at speed one and drop the flag
      new_pending = 1'b0;
      va          = 18'sd1;
    end else if (v == 18'sd0 && g > 18'sd1 && hit_ss) begin
      new_pending = 1'b1;
    end else begin
      // braking to the gap
      if (g <= v) begin
        if (v < vn || v <= 18'sd2) begin
          va = g - 18'sd1;
        end else begin
          va = (g - 18'sd1 < v - 18'sd1) ? g - 18'sd1 : v - 18'sd1;
        end
        if (va < 18'sd0) begin
          va = 18'sd0;
        end
        modified = 1'b1;
      end
      // braking bands against the car ahead
      if (va < g && g <= (va <<< 1)) begin
        if (va >= vn + 18'sd4) begin
          va       = va - 18'sd2;
          modified = 1'b1;
        end else if (vn + 18'sd2 <= va && va <= vn + 18'sd3) begin
          va       = va - 18'sd1;
          modified = 1'b1;
        end
        if (va < 18'sd0) begin
          va = 18'sd0;
        end
      end
      if (!modified && va < top_s && g > va) begin
        va = va + 18'sd1;
      end
      if (hit_sd && va > 18'sd0) begin
        va = va - 18'sd1;
      end
    end
    new_speed = va[5:0];
  end

endmodule

// File: hw/rtl/tcacu_mod_unit.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
// Depends on tcacu_pkg.
module tcacu_mod_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tcacu_pkg::DIV_BITS-1:0] dividend,
  input  logic [tcacu_pkg::DIV_BITS-1:0] divisor,
  output logic                          done,
  output logic [tcacu_pkg::DIV_BITS-1:0] remainder
);
  import tcacu_pkg::*;

  logic                run;
  logic [CNT_BITS-1:0] cnt;
  logic [DIV_BITS-1:0] dvd, dsr;
  logic [DIV_BITS:0]   rem, trial;

  assign trial     = {rem[DIV_BITS-1:0], dvd[DIV_BITS-1]};
  assign remainder = rem[DIV_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == CNT_BITS'(DIV_BITS - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
      cnt <= '0;
    end else if (run) begin
      rem <= (trial >= {1'b0, dsr}) ? trial - {1'b0, dsr} : trial;
      dvd <= {dvd[DIV_BITS-2:0], 1'b0};
      cnt <= cnt + CNT_BITS'(1);
    end
  end

endmodule

// File: hw/rtl/traffic_ca_car_update.sv
// Traffic cellular-automaton car update, top level.
// Depends on tcacu_pkg, tcacu_car_ram, tcacu_speed_rule, tcacu_mod_unit, assert_macros.svh.
//
// Use:
//   Command channel: drive item and raise start; the beat is taken at the rising
//   edge where start is high and busy is low. mode 0 updates the car in car_slot
//   from gap_cells, ahead_speed and the two draws; mode 1 puts the car on the track.
//   Result channel: done is high for exactly one cycle with result valid; the
//   receiver must take it then, it cannot stall the block.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high. Write registers only while the block is idle.
// Sequence:
//   One car at a time. The table read starts at the accepting edge, the new speed is
//   latched in S_LOOK, and the write-back and the result beat land at the edge that
//   ends S_MOVE, when done rises; the next beat is taken at the edge that ends the done
//   cycle. A wrap on a periodic track instead runs the iterative remainder unit in
//   S_WRAP, and the write-back and the result beat land when that unit is done.
//   The write-back lands before the next read, so the next item sees the fresh entry.
// Reset: rst (synchronous, active high) loads register defaults and idles the control;
//   the car table is not cleared, so a slot must be entered before it is updated.
`include "assert_macros.svh"

module traffic_ca_car_update (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  tcacu_pkg::cmd_t   item,
  output logic              busy,
  output logic              done,
  output tcacu_pkg::res_t   result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import tcacu_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_MOVE = 4'b0100,
    S_WRAP = 4'b1000
  } state_t;

  state_t   state;
  cfg_t     cfg;
  cmd_t     item_q;
  car_rec_t rec, wr_rec;

  logic [REC_BITS-1:0] rd_data;
  logic                accept;
  logic [5:0]          rule_speed, speed_q;
  logic                rule_pending, pend_q;
  logic [15:0]         base_q;
  logic [16:0]         road_len, sum_pos;
  logic                past_end, need_wrap, finish;
  logic                mod_start, mod_done;
  logic [16:0]         mod_rem;
  logic [15:0]         fin_pos;
  logic                fin_lap, fin_left;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign rec       = car_rec_t'(rd_data);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.model_options        <= 3'd0;
      cfg.top_speed            <= 6'd5;
      cfg.floor_speed          <= 6'd0;
      cfg.slowdown_threshold   <= 16'd0;
      cfg.accel_threshold      <= 16'hFFFF;
      cfg.slow_start_threshold <= 16'd0;
      cfg.road_length          <= 16'd1000;
      cfg.vehicle_length       <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODEL_OPTIONS:  cfg.model_options        <= cfg_data[2:0];
        CFG_TOP_SPEED:      cfg.top_speed            <= cfg_data[5:0];
        CFG_FLOOR_SPEED:    cfg.floor_speed          <= cfg_data[5:0];
        CFG_SLOWDOWN_THR:   cfg.slowdown_threshold   <= cfg_data;
        CFG_ACCEL_THR:      cfg.accel_threshold      <= cfg_data;
        CFG_SLOW_START_THR: cfg.slow_start_threshold <= cfg_data;
        CFG_ROAD_LENGTH:    cfg.road_length          <= cfg_data;
        CFG_VEHICLE_LENGTH: cfg.vehicle_length       <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // car state table: read on accept, write back when the result is final
  tcacu_car_ram #(
    .ADDR_BITS(SLOT_BITS),
    .DATA_BITS(REC_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (finish),
    .wr_addr (item_q.car_slot[SLOT_BITS-1:0]),
    .wr_data (wr_rec),
    .rd_en   (accept),
    .rd_addr (item.car_slot[SLOT_BITS-1:0]),
    .rd_data (rd_data)
  );

  tcacu_speed_rule u_rule (
    .cfg         (cfg),
    .item        (item_q),
    .cur         (rec),
    .new_speed   (rule_speed),
    .new_pending (rule_pending)
  );

  // move: zero road length stands for a full 16-bit track
  always_comb begin
    road_len = (cfg.road_length == 16'd0) ? 17'h10000 : {1'b0, cfg.road_length};
    if (item_q.mode == MODE_ENTER) begin
      sum_pos = {1'b0, base_q} + {13'd0, cfg.vehicle_length};
    end else begin
      sum_pos = {1'b0, base_q} + {11'd0, speed_q};
    end
    past_end  = (sum_pos >= road_len);
    need_wrap = past_end && cfg.model_options[OPT_PERIODIC];
    mod_start = (state == S_MOVE) && need_wrap;
  end

  tcacu_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (sum_pos),
    .divisor   (road_len),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // final position and flags, from the direct move or the wrapped remainder
  always_comb begin
    if (state == S_WRAP) begin
      fin_pos  = mod_rem[15:0];
      fin_lap  = 1'b1;
      fin_left = 1'b0;
      finish   = mod_done;
    end else begin
      fin_pos  = sum_pos[16] ? 16'hFFFF : sum_pos[15:0];
      fin_lap  = 1'b0;
      fin_left = past_end;
      finish   = (state == S_MOVE) && !need_wrap;
    end
    wr_rec.speed    = speed_q;
    wr_rec.pending  = pend_q;
    wr_rec.position = fin_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= finish;
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          state <= S_MOVE;
        end
        S_MOVE: begin
          state <= need_wrap ? S_WRAP : S_IDLE;
        end
        S_WRAP: begin
          if (mod_done) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload: hold the command, latch the new speed, register the result beat
  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
    end
    if (state == S_LOOK) begin
      if (item_q.mode == MODE_ENTER) begin
        speed_q <= cfg.top_speed;
        pend_q  <= 1'b0;
        base_q  <= 16'd0;
      end else begin
        speed_q <= rule_speed;
        pend_q  <= rule_pending;
        base_q  <= rec.position;
      end
    end
    if (finish) begin
      result.speed_out     <= speed_q;
      result.position_out  <= fin_pos;
      result.lap_done      <= fin_lap;
      result.left_road     <= fin_left;
      result.start_pending <= pend_q;
    end
  end

  `ASSERT_SAME(a_done_idle, done, !busy)
  `ASSERT_NEXT(a_accept_no_done, accept, busy && !done)
  `ASSERT_NEXT(a_wrap_done, (state == S_WRAP) && mod_done, done && !busy)
  `ASSERT_SAME(a_mod_only_wrap, mod_done, state == S_WRAP)

endmodule

// File: tb/tcacu_checker.sv
`timescale 1ns / 100ps
// Scoreboard for traffic_ca_car_update: watches the command, register and result ports
// and predicts every result from its own copy of the car table and registers.
// Depends on tcacu_pkg; hands its error and open-expectation counts to the testbench top.
module tcacu_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  tcacu_pkg::cmd_t   item,
  input  logic              done,
  input  tcacu_pkg::res_t   result,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output int                err_count,
  output int                open_count
);
  import tcacu_pkg::*;

  cfg_t        regs;
  logic [5:0]  speed_mem [CAR_SLOTS];
  logic        hold_mem  [CAR_SLOTS];
  logic [15:0] pos_mem   [CAR_SLOTS];
  res_t        car_results_q [$];
  int          beat_no;

  initial begin
    err_count  = 0;
    open_count = 0;
    beat_no    = 0;
  end

  task automatic report_error(input string msg);
    $display("ERROR: %0t ns result beat %0d: %s", $time, beat_no, msg);
    err_count = err_count + 1;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_error($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  function automatic bit draw_hits(input logic [15:0] draw, input logic [15:0] thr);
    return draw <= thr;
  endfunction

  // plain rule: speed up, cap to gap, slow at random (twice if sped up, true slowdown)
  function automatic int basic_speed(input int v, input int gap,
                                     input logic [15:0] d1, input logic [15:0] d2);
    bit sped_up;
    sped_up = 1'b0;
    if (draw_hits(d1, regs.accel_threshold) && v < int'(regs.top_speed) && gap > v) begin
      v = v + 1;
      sped_up = 1'b1;
    end
    if (v > gap) v = gap;
    if (draw_hits(d2, regs.slowdown_threshold) && v > int'(regs.floor_speed)) begin
      v = v - 1;
      if (regs.model_options[OPT_TRUE_SLOWDOWN] && sped_up && v > 0) v = v - 1;
    end
    return v;
  endfunction

  // slow-to-stop rule; hold carries the slow-start flag in and out
  function automatic int sts_speed(input int v, input int gap, input int vn,
                                   input logic [15:0] d1, input logic [15:0] d2,
                                   inout bit hold);
    bit braked;
    braked = 1'b0;
    if (hold) begin
      hold = 1'b0;
      return 1;
    end
    if (v == 0 && gap > 1 && draw_hits(d1, regs.slow_start_threshold)) begin
      hold = 1'b1;
      return v;
    end
    if (gap <= v) begin
      if (v < vn || v <= 2) v = gap - 1;
      else v = (gap - 1 < v - 1) ? gap - 1 : v - 1;
      if (v < 0) v = 0;
      braked = 1'b1;
    end
    if (v < gap && gap <= 2 * v) begin
      if (v >= vn + 4) begin
        v = v - 2;
        braked = 1'b1;
      end else if (vn + 2 <= v && v <= vn + 3) begin
        v = v - 1;
        braked = 1'b1;
      end
      if (v < 0) v = 0;
    end
    if (!braked && v < int'(regs.top_speed) && gap > v) v = v + 1;
    if (draw_hits(d2, regs.slowdown_threshold) && v > 0) v = v - 1;
    return v;
  endfunction

  function automatic res_t advance(input logic [15:0] pos, input int unsigned cells);
    res_t r;
    int unsigned span;
    int unsigned p;
    r = '0;
    span = (regs.road_length == 16'd0) ? 32'd65536 : 32'(regs.road_length);
    p = 32'(pos) + cells;
    if (p >= span) begin
      if (regs.model_options[OPT_PERIODIC]) begin
        p = p % span;
        r.lap_done = 1'b1;
      end else begin
        r.left_road = 1'b1;
      end
    end
    if (p > 32'd65535) p = 32'd65535;
    r.position_out = p[15:0];
    return r;
  endfunction

  function automatic res_t predict_car(input cmd_t c);
    res_t r;
    int v;
    bit hold;
    logic [7:0] s;
    s = c.car_slot;
    hold = hold_mem[s];
    if (c.mode == MODE_ENTER) begin
      v = int'(regs.top_speed);
      hold = 1'b0;
      r = advance(16'd0, 32'(regs.vehicle_length));
    end else begin
      if (regs.model_options[OPT_SLOW_TO_STOP]) begin
        v = sts_speed(int'(speed_mem[s]), int'(c.gap_cells), int'($signed(c.ahead_speed)),
                      c.draw_one, c.draw_two, hold);
      end else begin
        v = basic_speed(int'(speed_mem[s]), int'(c.gap_cells), c.draw_one, c.draw_two);
      end
      v = v & 63;
      r = advance(pos_mem[s], 32'(v));
    end
    speed_mem[s]    = 6'(v);
    hold_mem[s]     = hold;
    pos_mem[s]      = r.position_out;
    r.speed_out     = 6'(v);
    r.start_pending = hold;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      regs.model_options        = 3'd0;
      regs.top_speed            = 6'd5;
      regs.floor_speed          = 6'd0;
      regs.slowdown_threshold   = 16'd0;
      regs.accel_threshold      = 16'hFFFF;
      regs.slow_start_threshold = 16'd0;
      regs.road_length          = 16'd1000;
      regs.vehicle_length       = 4'd1;
    end else begin
      if (done) begin
        beat_no = beat_no + 1;
        if (car_results_q.size() == 0) begin
          report_error("result with nothing expected");
        end else begin
          want = car_results_q.pop_front();
          check_field("speed_out", 16'(result.speed_out), 16'(want.speed_out));
          check_field("position_out", result.position_out, want.position_out);
          check_field("lap_done", 16'(result.lap_done), 16'(want.lap_done));
          check_field("left_road", 16'(result.left_road), 16'(want.left_road));
          check_field("start_pending", 16'(result.start_pending), 16'(want.start_pending));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODEL_OPTIONS:  regs.model_options        = cfg_data[2:0];
          CFG_TOP_SPEED:      regs.top_speed            = cfg_data[5:0];
          CFG_FLOOR_SPEED:    regs.floor_speed          = cfg_data[5:0];
          CFG_SLOWDOWN_THR:   regs.slowdown_threshold   = cfg_data;
          CFG_ACCEL_THR:      regs.accel_threshold      = cfg_data;
          CFG_SLOW_START_THR: regs.slow_start_threshold = cfg_data;
          CFG_ROAD_LENGTH:    regs.road_length          = cfg_data;
          CFG_VEHICLE_LENGTH: regs.vehicle_length       = cfg_data[3:0];
          default: ;
        endcase
      end
      if (start && !busy) car_results_q.push_back(predict_car(item));
    end
    open_count = car_results_q.size();
  end

endmodule

// File: tb/tb_traffic_ca_car_update.sv
`timescale 1ns / 100ps
// Testbench top for traffic_ca_car_update: drives command beats and register writes,
// leaves prediction and comparison to tcacu_checker and prints the verdict.
// Depends on tcacu_pkg, tcacu_checker and the RTL of the block.
module tb_traffic_ca_car_update;
  import tcacu_pkg::*;

  // hard stop limit on the clock count of the whole run
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 20;
  // one car at speed 63 needs about 1040 steps to run past cell 65535
  localparam int HAUL_STEPS  = 1070;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  cmd_t        item;
  logic        busy;
  logic        done;
  res_t        result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  int          err_count;
  int          open_count;
  int          cycles = 0;

  bit          idle_on;
  logic [5:0]  cur_top;
  logic [7:0]  live_q [$];
  bit          slot_live [CAR_SLOTS];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  traffic_ca_car_update u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tcacu_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .item       (item),
    .done       (done),
    .result     (result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .err_count  (err_count),
    .open_count (open_count)
  );

  // Hard stop: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic cmd_t mk_cmd(input logic mode, input logic [7:0] slot,
                                  input logic [15:0] gap, input logic [7:0] ahead,
                                  input logic [15:0] d1, input logic [15:0] d2);
    cmd_t c;
    c.mode        = mode;
    c.car_slot    = slot;
    c.gap_cells   = gap;
    c.ahead_speed = ahead;
    c.draw_one    = d1;
    c.draw_two    = d2;
    return c;
  endfunction

  // Threshold pick: lean on the two extremes, otherwise anything.
  function automatic logic [15:0] pick_thr();
    case ($urandom_range(0, 4))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // One beat of traffic. Most beats update a car already on the road with a gap and
  // a leader speed near the current top speed, so the braking bands and the cap to
  // the gap actually fire. A few beats enter any slot; the rest are raw noise.
  // Updates only ever go to slots that were entered, since the table is not cleared.
  function automatic cmd_t next_traffic();
    cmd_t c;
    int roll;
    int lim;
    c.mode        = MODE_UPDATE;
    c.car_slot    = live_q[$urandom_range(0, live_q.size() - 1)];
    c.gap_cells   = 16'($urandom);
    c.ahead_speed = 8'($urandom);
    c.draw_one    = 16'($urandom);
    c.draw_two    = 16'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      c.mode     = MODE_ENTER;
      c.car_slot = 8'($urandom);
    end else if (roll < 90) begin
      lim = 2 * int'(cur_top) + 4;
      case ($urandom_range(0, 5))
        0:       c.gap_cells = 16'hFFFF;
        1:       ;
        default: c.gap_cells = 16'($urandom_range(0, lim));
      endcase
      case ($urandom_range(0, 4))
        0:       c.ahead_speed = 8'hFF;    // no car visible
        1:       ;
        default: c.ahead_speed = 8'($urandom_range(0, int'(cur_top) + 5));
      endcase
    end
    return c;
  endfunction

  // Send one command beat. Entered at a falling edge; returns at the falling edge
  // after the accepting rising edge with start still high, so the next beat can
  // follow back to back without start dropping in between.
  task automatic send_cmd(input cmd_t c);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      // idle burst: drop start before driving the beat
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    start <= 1'b1;
    item  <= c;
    // hold the beat until the block takes it (busy sampled before the edge updates it)
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (c.mode == MODE_ENTER && !slot_live[c.car_slot]) begin
      slot_live[c.car_slot] = 1'b1;
      live_q.push_back(c.car_slot);
    end
  endtask

  // Drop start and wait until every expected result has come back and the block is idle.
  task automatic settle();
    start <= 1'b0;
    @(negedge clk);
    while (open_count != 0 || busy) @(negedge clk);
  endtask

  // Drain, then write all eight registers, one beat each, lowering valid once at the end.
  task automatic load_regs(input cfg_t v);
    logic [15:0] vals [8];
    settle();
    vals[CFG_MODEL_OPTIONS]  = 16'(v.model_options);
    vals[CFG_TOP_SPEED]      = 16'(v.top_speed);
    vals[CFG_FLOOR_SPEED]    = 16'(v.floor_speed);
    vals[CFG_SLOWDOWN_THR]   = v.slowdown_threshold;
    vals[CFG_ACCEL_THR]      = v.accel_threshold;
    vals[CFG_SLOW_START_THR] = v.slow_start_threshold;
    vals[CFG_ROAD_LENGTH]    = v.road_length;
    vals[CFG_VEHICLE_LENGTH] = 16'(v.vehicle_length);
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    cur_top = v.top_speed;
  endtask

  initial begin
    cfg_t setup;
    cmd_t c;
    logic [7:0] hauler;
    int k;

    rst       = 1'b1;
    start     = 1'b0;
    item      = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    idle_on   = 1'b1;
    cur_top   = 6'd5;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ---- directed: reset settings (plain rule, open track of 1000, top speed 5) ----
    send_cmd(mk_cmd(MODE_ENTER, 8'd0, 16'd0, 8'h00, 16'd0, 16'd0));
    send_cmd(mk_cmd(MODE_ENTER, 8'd255, 16'hFFFF, 8'h80, 16'hFFFF, 16'hFFFF));
    // at top speed with a huge gap: no acceleration, slowdown hits on a zero draw
    send_cmd(mk_cmd(MODE_UPDATE, 8'd0, 16'hFFFF, 8'hFF, 16'hFFFF, 16'd0));
    // zero gap stops the car
    send_cmd(mk_cmd(MODE_UPDATE, 8'd0, 16'd0, 8'h7F, 16'd0, 16'hFFFF));
    send_cmd(mk_cmd(MODE_UPDATE, 8'd255, 16'd2, 8'h80, 16'd0, 16'hFFFF));

    // ---- directed: periodic track of 7 cells, true slowdown, always slow down ----
    setup.model_options        = '0;
    setup.model_options[OPT_PERIODIC]      = 1'b1;
    setup.model_options[OPT_TRUE_SLOWDOWN] = 1'b1;
    setup.top_speed            = 6'd63;
    setup.floor_speed          = 6'd0;
    setup.slowdown_threshold   = 16'hFFFF;
    setup.accel_threshold      = 16'hFFFF;
    setup.slow_start_threshold = 16'd0;
    setup.road_length          = 16'd7;
    setup.vehicle_length       = 4'd15;
    load_regs(setup);
    // a 15-cell car on a 7-cell ring wraps already when it enters
    send_cmd(mk_cmd(MODE_ENTER, 8'd1, 16'd0, 8'h00, 16'd0, 16'd0));
    // at top speed: single slowdown; one below top: accelerate, then slow twice
    send_cmd(mk_cmd(MODE_UPDATE, 8'd1, 16'hFFFF, 8'hFF, 16'd0, 16'd0));
    send_cmd(mk_cmd(MODE_UPDATE, 8'd1, 16'hFFFF, 8'hFF, 16'd0, 16'd0));
    // from standstill the second slowdown must not go below zero
    send_cmd(mk_cmd(MODE_UPDATE, 8'd0, 16'd1, 8'hFF, 16'd0, 16'd0));

    // ---- directed: slow-to-stop on a ring whose length register is zero ----
    setup.model_options        = '0;
    setup.model_options[OPT_SLOW_TO_STOP] = 1'b1;
    setup.model_options[OPT_PERIODIC]     = 1'b1;
    setup.top_speed            = 6'd5;
    setup.slowdown_threshold   = 16'd0;
    setup.slow_start_threshold = 16'hFFFF;
    setup.road_length          = 16'd0;
    setup.vehicle_length       = 4'd1;
    load_regs(setup);
    // standing car with room ahead: slow start pends, then the next step moves at 1
    send_cmd(mk_cmd(MODE_UPDATE, 8'd0, 16'd2, 8'hFF, 16'd0, 16'hFFFF));
    send_cmd(mk_cmd(MODE_UPDATE, 8'd0, 16'd2, 8'hFF, 16'd0, 16'hFFFF));
    send_cmd(mk_cmd(MODE_ENTER, 8'd3, 16'd0, 8'h00, 16'd0, 16'd0));
    // gap at or below speed against a slower leader, then the one-step braking band
    send_cmd(mk_cmd(MODE_UPDATE, 8'd3, 16'd3, 8'h00, 16'd0, 16'hFFFF));
    // leader faster than us: brake to gap minus one
    send_cmd(mk_cmd(MODE_UPDATE, 8'd3, 16'd1, 8'd10, 16'd0, 16'hFFFF));
    send_cmd(mk_cmd(MODE_UPDATE, 8'd3, 16'd4, 8'hFF, 16'd0, 16'hFFFF));
    send_cmd(mk_cmd(MODE_UPDATE, 8'd3, 16'd4, 8'hFF, 16'd0, 16'hFFFF));
    // leader speed far below -1: the two-step band clamps at zero
    send_cmd(mk_cmd(MODE_UPDATE, 8'd3, 16'd2, 8'h80, 16'hFFFF, 16'hFFFF));
    send_cmd(mk_cmd(MODE_ENTER, 8'd4, 16'd0, 8'h00, 16'd0, 16'd0));
    send_cmd(mk_cmd(MODE_UPDATE, 8'd4, 16'd8, 8'd3, 16'hFFFF, 16'hFFFF));
    send_cmd(mk_cmd(MODE_UPDATE, 8'd4, 16'd3, 8'h00, 16'hFFFF, 16'hFFFF));

    // ---- random phases, each under fresh register settings ----
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 7) begin
        // Long haul: one car at speed 63 on an open track whose length register is
        // zero, driven until it passes cell 65535 and the position saturates.
        // Floor speed 63 keeps the plain slowdown from ever acting.
        setup.model_options        = '0;
        setup.top_speed            = 6'd63;
        setup.floor_speed          = 6'd63;
        setup.slowdown_threshold   = 16'd0;
        setup.accel_threshold      = 16'hFFFF;
        setup.slow_start_threshold = 16'd0;
        setup.road_length          = 16'd0;
        setup.vehicle_length       = 4'd15;
        load_regs(setup);
        idle_on = 1'b1;
        hauler  = 8'($urandom);
        send_cmd(mk_cmd(MODE_ENTER, hauler, 16'($urandom), 8'($urandom),
                        16'($urandom), 16'($urandom)));
        k = 0;
        while (k < HAUL_STEPS) begin
          if ($urandom_range(0, 9) == 0) begin
            // other traffic in between; keep it off the hauler
            c = next_traffic();
            if (c.car_slot != hauler) send_cmd(c);
          end else begin
            send_cmd(mk_cmd(MODE_UPDATE, hauler, 16'($urandom_range(63, 65535)),
                            8'($urandom), 16'($urandom), 16'($urandom)));
            k++;
          end
        end
      end

      setup.model_options = 3'($urandom);
      case ($urandom_range(0, 3))
        0:       setup.top_speed = 6'd1;
        1:       setup.top_speed = 6'd63;
        2:       setup.top_speed = 6'($urandom);
        default: setup.top_speed = 6'($urandom_range(2, 12));
      endcase
      case ($urandom_range(0, 3))
        0:       setup.floor_speed = 6'd0;
        1:       setup.floor_speed = 6'd63;
        default: setup.floor_speed = 6'($urandom_range(0, int'(setup.top_speed)));
      endcase
      setup.slowdown_threshold   = pick_thr();
      setup.accel_threshold      = pick_thr();
      setup.slow_start_threshold = pick_thr();
      case ($urandom_range(0, 6))
        0:       setup.road_length = 16'd1;
        1:       setup.road_length = 16'hFFFF;
        2:       setup.road_length = 16'd0;
        3:       setup.road_length = 16'($urandom);
        default: setup.road_length = 16'($urandom_range(1, 400));
      endcase
      case ($urandom_range(0, 3))
        0:       setup.vehicle_length = 4'd1;
        1:       setup.vehicle_length = 4'd15;
        default: setup.vehicle_length = 4'($urandom);
      endcase
      load_regs(setup);

      // no idling at all in the last stretch of the run
      idle_on = (ph < PHASES - 2) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_cmd(next_traffic());
      end
    end

    // wind down: collect every result, then watch the block stay quiet before the verdict
    settle();
    repeat (8) @(negedge clk);
    if (err_count == 0 && open_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: traffic_ca_car_update.f
+incdir+hw/rtl
hw/rtl/tcacu_pkg.sv
hw/rtl/tcacu_car_ram.sv
hw/rtl/tcacu_speed_rule.sv
hw/rtl/tcacu_mod_unit.sv
hw/rtl/traffic_ca_car_update.sv
tb/tcacu_checker.sv
tb/tb_traffic_ca_car_update.sv
